FILE: hdl/tfw_pkg.sv
// Shared types, constants and register codes of the text find block.
// No dependencies; the modules, the checker and the testbench import this package.
package tfw_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int TEXT_MAX    = 65536;

	localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
	localparam int PLEN_W    = 5;
	localparam int POS_W     = $clog2(TEXT_MAX + 1);
	localparam int SEL_W     = 16;
	localparam int END_W     = 17;
	localparam int CFG_W     = 64;
	localparam int REG_IDX_W = 3;
	localparam int WIN_D     = PATTERN_MAX + 1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PAT_LO    = 3'd0,
		REG_PAT_HI    = 3'd1,
		REG_PAT_LEN   = 3'd2,
		REG_MATCH_CASE = 3'd3,
		REG_WHOLE_WORD = 3'd4,
		REG_SEARCH_DOWN = 3'd5,
		REG_SEL_START = 3'd6,
		REG_SEL_END   = 3'd7
	} tfw_reg_t;

	typedef logic [PATTERN_MAX-1:0][7:0] tfw_pat_t;
	typedef logic [WIN_D-1:0][7:0] tfw_win_t;

	typedef struct packed {
		tfw_pat_t         pat;
		logic [LEN_W-1:0] len;
		logic             match_case;
		logic             whole_word;
		logic             search_down;
		logic [SEL_W-1:0] sel_start;
		logic [SEL_W-1:0] sel_end;
	} tfw_cfg_t;

	typedef struct packed {
		logic exact;
		logic folded;
		logic pre_delim;
	} tfw_cand_t;

	typedef struct packed {
		logic             sel_holds;
		logic             have_match;
		logic [SEL_W-1:0] best;
	} tfw_srch_t;

endpackage

FILE: hdl/tfw_in_if.sv
// Input channel: one text byte per item with its end mark.
// Depends on nothing.
interface tfw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink (input valid, input text_char, input last_char, output ready);
endinterface

FILE: hdl/tfw_out_if.sv
// Result channel: one search result per text.
// Depends on nothing.
interface tfw_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] match_start;
	logic [16:0] match_end;
	logic        text_overflow;

	modport source (output valid, output found, output match_start, output match_end,
		output text_overflow, input ready);
	modport sink (input valid, input found, input match_start, input match_end,
		input text_overflow, output ready);
endinterface

FILE: hdl/tfw_cfg.sv
// Configuration register file of the text find block.
// Depends on tfw_pkg.
module tfw_cfg
	import tfw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output tfw_cfg_t             cfg
);

	logic [63:0]       pat_lo_q;
	logic [63:0]       pat_hi_q;
	logic [PLEN_W-1:0] len_q;
	logic              match_case_q;
	logic              whole_word_q;
	logic              search_down_q;
	logic [SEL_W-1:0]  sel_start_q;
	logic [SEL_W-1:0]  sel_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q      <= '0;
			pat_hi_q      <= '0;
			len_q         <= PLEN_W'(1);
			match_case_q  <= 1'b0;
			whole_word_q  <= 1'b0;
			search_down_q <= 1'b1;
			sel_start_q   <= '0;
			sel_end_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_LO:      pat_lo_q      <= cfg_wdata[63:0];
				REG_PAT_HI:      pat_hi_q      <= cfg_wdata[63:0];
				REG_PAT_LEN:     len_q         <= cfg_wdata[PLEN_W-1:0];
				REG_MATCH_CASE:  match_case_q  <= cfg_wdata[0];
				REG_WHOLE_WORD:  whole_word_q  <= cfg_wdata[0];
				REG_SEARCH_DOWN: search_down_q <= cfg_wdata[0];
				REG_SEL_START:   sel_start_q   <= cfg_wdata[SEL_W-1:0];
				REG_SEL_END:     sel_end_q     <= cfg_wdata[SEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (i < 8)
				cfg.pat[i] = pat_lo_q[8*i +: 8];
			else if (i < 16)
				cfg.pat[i] = pat_hi_q[8*(i-8) +: 8];
			else
				cfg.pat[i] = 8'h00;
		end
		// clamp length into 1 .. PATTERN_MAX
		if (len_q == '0)
			cfg.len = LEN_W'(1);
		else if (int'(len_q) > PATTERN_MAX)
			cfg.len = LEN_W'(PATTERN_MAX);
		else
			cfg.len = LEN_W'(len_q);
		cfg.match_case  = match_case_q;
		cfg.whole_word  = whole_word_q;
		cfg.search_down = search_down_q;
		cfg.sel_start   = sel_start_q;
		cfg.sel_end     = sel_end_q;
	end

endmodule

FILE: hdl/tfw_cand.sv
// Compares one candidate alignment of the byte window against the pattern.
// Depends on tfw_pkg. Window byte len-1-i lines up with pattern byte i.
module tfw_cand
	import tfw_pkg::*;
(
	input  tfw_win_t  win,
	input  tfw_cfg_t  cfg,
	output tfw_cand_t res
);

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]})
			r = c + 8'd32;
		return r;
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_COMMA, CH_DOT, CH_CR};
	endfunction

	always_comb begin
		logic [LEN_W-1:0] idx;
		logic [7:0]       t;
		res.exact  = 1'b1;
		res.folded = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			idx = cfg.len - LEN_W'(i + 1);
			t   = win[idx];
			if (i < int'(cfg.len)) begin
				if (t != cfg.pat[i])
					res.exact = 1'b0;
				if (fold(t) != fold(cfg.pat[i]))
					res.folded = 1'b0;
			end
		end
		res.pre_delim = is_delim(win[cfg.len]);
	end

endmodule

FILE: hdl/text_find_with_word_match.sv
// Top level of the text find block: input stage, search state, result register.
// Depends on tfw_pkg, tfw_in_if, tfw_out_if, tfw_cfg, tfw_cand.
//
//  channel   dir   handshake        payload
//  text      in    valid/ready      text_char[7:0], last_char
//  result    out   valid/ready      found, match_start[15:0], match_end[16:0], text_overflow
//  cfg_*     in    cfg_we           cfg_index[2:0], cfg_wdata[63:0]
//
// One byte per cycle sustained, but for a last byte held by a full result register;
// the window is compared at all pattern positions while a byte sits in the input stage.
// The result register takes the result when the input stage passes on the last byte.
// Reset clears the search state and the handshake flags; no clearing pass.
// Only the last byte waits on a full result register; other bytes keep moving.
module text_find_with_word_match
	import tfw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	tfw_in_if.sink               text,
	tfw_out_if.source            result,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	tfw_cfg_t cfg;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	tfw_win_t         win_q;
	logic [POS_W-1:0] pos_q;
	tfw_srch_t        srch_q;
	logic             ovf_q;

	logic             out_valid_q;
	logic             out_found_q;
	logic [SEL_W-1:0] out_start_q;
	logic [END_W-1:0] out_end_q;
	logic             out_ovf_q;

	logic             advance;
	logic             room;
	tfw_win_t         win_sh;
	tfw_win_t         win_b;
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] diff_a;
	logic [POS_W-1:0] diff_b;
	logic             cand_a_v;
	logic             cand_b_v;
	tfw_cand_t        cand_a;
	tfw_cand_t        cand_b;
	tfw_srch_t        srch_a;
	tfw_srch_t        srch_b;

	tfw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// candidate ending just before the new byte; the new byte is its trailing char
	tfw_cand u_cand_a (
		.win (win_q),
		.cfg (cfg),
		.res (cand_a)
	);

	// candidate ending at the text end
	tfw_cand u_cand_b (
		.win (win_b),
		.cfg (cfg),
		.res (cand_b)
	);

	function automatic logic is_delim(input logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_COMMA, CH_DOT, CH_CR};
	endfunction

	function automatic tfw_srch_t consider(input tfw_srch_t st, input logic [SEL_W-1:0] p,
		input tfw_cand_t c, input logic post, input tfw_cfg_t k);
		tfw_srch_t        r;
		logic             hit;
		logic [SEL_W:0]   origin;
		r   = st;
		hit = k.match_case ? c.exact : c.folded;
		if (k.whole_word)
			hit = hit && ((p == '0) || c.pre_delim) && post;
		if (p == k.sel_start)
			r.sel_holds = (k.sel_end >= k.sel_start) &&
				((k.sel_end - k.sel_start) == SEL_W'(k.len)) && c.folded;
		if (k.search_down) begin
			origin = {1'b0, k.sel_start} + (SEL_W+1)'(r.sel_holds);
			if (!r.have_match && hit && ({1'b0, p} >= origin)) begin
				r.have_match = 1'b1;
				r.best       = p;
			end
		end else if (hit && ((p < k.sel_start) || ((p == k.sel_start) && !r.sel_holds))) begin
			r.have_match = 1'b1;
			r.best       = p;
		end
		return r;
	endfunction

	assign advance    = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign text.ready = !valid_s1 || advance;

	always_comb begin
		room     = pos_q < POS_W'(TEXT_MAX);
		win_sh   = {win_q[WIN_D-2:0], char_s1};
		win_b    = room ? win_sh : win_q;
		pos_n    = room ? pos_q + POS_W'(1) : pos_q;
		diff_a   = pos_q - POS_W'(cfg.len);
		diff_b   = pos_n - POS_W'(cfg.len);
		cand_a_v = room && (pos_q >= POS_W'(cfg.len));
		cand_b_v = last_s1 && (pos_n >= POS_W'(cfg.len));
		srch_a   = cand_a_v ? consider(srch_q, diff_a[SEL_W-1:0], cand_a,
			is_delim(char_s1), cfg) : srch_q;
		srch_b   = cand_b_v ? consider(srch_a, diff_b[SEL_W-1:0], cand_b,
			cfg.search_down, cfg) : srch_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.text_char;
			last_s1 <= text.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			pos_q  <= '0;
			srch_q <= '0;
			ovf_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				// text done: return the search to its idle values
				win_q  <= '0;
				pos_q  <= '0;
				srch_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				win_q  <= win_b;
				pos_q  <= pos_n;
				srch_q <= srch_b;
				ovf_q  <= ovf_q || !room;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_found_q <= srch_b.have_match;
			out_start_q <= srch_b.have_match ? srch_b.best : '0;
			out_end_q   <= srch_b.have_match ?
				END_W'(srch_b.best) + END_W'(cfg.len) : '0;
			out_ovf_q   <= ovf_q || !room;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.found         = out_found_q;
	assign result.match_start   = out_start_q;
	assign result.match_end     = out_end_q;
	assign result.text_overflow = out_ovf_q;

endmodule

FILE: hdl/tfw_chk.sv
// Port-level checker for the text find block, bound to the top level.
// Depends on tfw_pkg and on the port names of text_find_with_word_match.
module tfw_chk
	import tfw_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_last,
	input logic             out_valid,
	input logic             out_ready,
	input logic             found,
	input logic [SEL_W-1:0] match_start,
	input logic [END_W-1:0] match_end,
	input logic             text_overflow
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) &&
		$stable(match_start) && $stable(match_end) && $stable(text_overflow))
		else $error("result changed while stalled");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_start == '0 && match_end == '0)
		else $error("empty result carries a position");

	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> match_end > {1'b0, match_start} &&
		(match_end - {1'b0, match_start}) <= END_W'(PATTERN_MAX))
		else $error("match span outside pattern length");

	// a fresh result follows the acceptance of a last byte, which passes through the input
	// stage and then into the result register
	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("result without a last byte");

endmodule

bind text_find_with_word_match tfw_chk u_tfw_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (text.valid),
	.in_ready      (text.ready),
	.in_last       (text.last_char),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.found         (result.found),
	.match_start   (result.match_start),
	.match_end     (result.match_end),
	.text_overflow (result.text_overflow)
);

FILE: tb/sv/tb_text_find_with_word_match.sv
// Self-checking testbench of the text find block: streams texts, predicts each search result.
// Depends on tfw_pkg, tfw_in_if, tfw_out_if and the text_find_with_word_match top level.
`timescale 1ns / 100ps

module tb_text_find_with_word_match;
	import tfw_pkg::*;

	localparam int WIN_DEPTH = PATTERN_MAX + 2;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_item_t;

	typedef struct packed {
		logic        found;
		logic [15:0] mstart;
		logic [16:0] mend;
		logic        ovf;
	} find_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	tfw_in_if  text_ch();
	tfw_out_if result_ch();

	text_find_with_word_match uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// register copies as the block sees them
	logic [63:0] cfg_pat_lo;
	logic [63:0] cfg_pat_hi;
	logic [4:0]  cfg_len;
	logic        cfg_case;
	logic        cfg_word;
	logic        cfg_down;
	logic [15:0] cfg_sel_start;
	logic [15:0] cfg_sel_end;

	// search state of the predictor
	logic [7:0] win_q [0:WIN_DEPTH-1];
	int         byte_pos;
	bit         sel_holds;
	bit         have_match;
	int         best_pos;
	bit         overflow_seen;

	text_item_t   pending[$];
	find_result_t results_due[$];

	int send_idle_pct;
	int recv_stall_pct;
	bit text_taken;
	int mismatches;
	int texts_done;
	int found_seen;
	int overflow_texts;
	int bytes_sent;

	find_result_t got;
	find_result_t want;

	function automatic logic [7:0] fold(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic bit is_delim(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_COMMA || c == CH_DOT || c == CH_CR;
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A;
	endfunction

	function automatic logic [7:0] pat_byte(int i);
		return (i < 8) ? cfg_pat_lo[8*i +: 8] : cfg_pat_hi[8*(i-8) +: 8];
	endfunction

	function automatic int eff_len();
		int m;
		m = int'(cfg_len);
		if (m == 0) m = 1;
		if (m > PATTERN_MAX) m = PATTERN_MAX;
		return m;
	endfunction

	function automatic void clear_search();
		for (int i = 0; i < WIN_DEPTH; i++) win_q[i] = 8'h00;
		byte_pos = 0;
		sel_holds = 1'b0;
		have_match = 1'b0;
		best_pos = 0;
		overflow_seen = 1'b0;
	endfunction

	// Judge the candidate at position p; text[p+i] sits at win_q[off+m-1-i].
	function automatic void weigh_candidate(int p, int off, int m, bit at_end);
		bit         exact;
		bit         folded;
		bit         hit;
		bit         pre;
		bit         post;
		logic [7:0] t;
		logic [7:0] c;
		int         origin;
		exact = 1'b1;
		folded = 1'b1;
		for (int i = 0; i < m; i++) begin
			t = win_q[off + m - 1 - i];
			c = pat_byte(i);
			if (t != c) exact = 1'b0;
			if (fold(t) != fold(c)) folded = 1'b0;
		end
		hit = cfg_case ? exact : folded;
		if (cfg_word) begin
			pre = (p == 0) || is_delim(win_q[off + m]);
			// the text end counts as a delimiter only when searching down
			post = at_end ? cfg_down : is_delim(win_q[0]);
			hit = hit && pre && post;
		end
		if (p == int'(cfg_sel_start))
			sel_holds = cfg_sel_end >= cfg_sel_start &&
				int'(cfg_sel_end) - int'(cfg_sel_start) == m && folded;
		if (cfg_down) begin
			origin = int'(cfg_sel_start) + (sel_holds ? 1 : 0);
			if (!have_match && hit && p >= origin) begin
				have_match = 1'b1;
				best_pos = p;
			end
		end else if (hit && (p < int'(cfg_sel_start) ||
				(p == int'(cfg_sel_start) && !sel_holds))) begin
			have_match = 1'b1;
			best_pos = p;
		end
	endfunction

	function automatic void scan_byte(logic [7:0] ch, logic last);
		int           m;
		find_result_t r;
		m = eff_len();
		if (byte_pos < TEXT_MAX) begin
			for (int i = WIN_DEPTH - 1; i > 0; i--) win_q[i] = win_q[i-1];
			win_q[0] = ch;
			byte_pos++;
			if (byte_pos - 1 >= m) weigh_candidate(byte_pos - 1 - m, 1, m, 1'b0);
		end else begin
			overflow_seen = 1'b1;
		end
		if (last) begin
			if (byte_pos >= m) weigh_candidate(byte_pos - m, 0, m, 1'b1);
			r.found = have_match;
			r.mstart = have_match ? 16'(best_pos) : 16'd0;
			r.mend = have_match ? 17'(best_pos + m) : 17'd0;
			r.ovf = overflow_seen;
			results_due.push_back(r);
			clear_search();
		end
	endfunction

	// Driver: hold an offered item until taken, otherwise offer the next one or idle.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(text_ch.valid && !text_taken)) begin
				if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					text_ch.valid <= 1'b1;
					text_ch.text_char <= pending[0].ch;
					text_ch.last_char <= pending[0].last;
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
			text_taken = 1'b0;
			result_ch.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// Monitor: predict on every accepted byte, check every accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready) begin
				scan_byte(text_ch.text_char, text_ch.last_char);
				void'(pending.pop_front());
				text_taken = 1'b1;
				bytes_sent++;
			end
			if (result_ch.valid && result_ch.ready) begin
				got.found = result_ch.found;
				got.mstart = result_ch.match_start;
				got.mend = result_ch.match_end;
				got.ovf = result_ch.text_overflow;
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none pending:", $realtime,
							" found=%0b start=%0d end=%0d ovf=%0b",
							got.found, got.mstart, got.mend, got.ovf);
				end else begin
					want = results_due.pop_front();
					if (got.found !== want.found || got.mstart !== want.mstart ||
							got.mend !== want.mend || got.ovf !== want.ovf) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp found=%0b start=%0d end=%0d ovf=%0b,",
								$realtime, want.found, want.mstart, want.mend, want.ovf,
								" got found=%0b start=%0d end=%0d ovf=%0b",
								got.found, got.mstart, got.mend, got.ovf);
					end
					texts_done++;
					if (want.found) found_seen++;
					if (want.ovf) overflow_texts++;
				end
			end
		end
	end

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			pending.push_back('{s[i], i == s.len() - 1});
	endfunction

	function automatic void queue_bytes(logic [7:0] txt[$]);
		for (int i = 0; i < txt.size(); i++)
			pending.push_back('{txt[i], i == txt.size() - 1});
	endfunction

	function automatic logic [127:0] pack_str(string s);
		logic [127:0] p;
		p = '0;
		for (int i = 0; i < s.len() && i < 16; i++) p[8*i +: 8] = s[i];
		return p;
	endfunction

	function automatic logic [7:0] pick_delim();
		case ($urandom_range(4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_COMMA;
			3: return CH_DOT;
			default: return CH_CR;
		endcase
	endfunction

	// Mostly a few letters in both cases, so that near misses are common.
	function automatic logic [7:0] pick_symbol();
		int         r;
		logic [7:0] b;
		r = $urandom_range(99);
		if (r < 55) begin
			b = 8'h61 + 8'($urandom_range(5));
			if ($urandom_range(1)) b ^= 8'h20;
		end else if (r < 70) begin
			b = 8'h41 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h20 : 8'h00);
		end else if (r < 80) begin
			b = 8'h30 + 8'($urandom_range(9));
		end else if (r < 88) begin
			b = pick_delim();
		end else begin
			b = 8'($urandom_range(255));
		end
		return b;
	endfunction

	function automatic void build_text(logic [127:0] pat, int m, ref logic [7:0] txt[$],
			ref int copies[$]);
		int         target;
		int         r;
		logic [7:0] b;
		txt.delete();
		copies.delete();
		target = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range(64, 25);
		while (txt.size() < target) begin
			r = $urandom_range(99);
			if (r < 35) begin
				copies.push_back(txt.size());
				for (int i = 0; i < m; i++) begin
					b = pat[8*i +: 8];
					if (is_letter(b) && $urandom_range(3) == 0) b ^= 8'h20;
					txt.push_back(b);
				end
			end else if (r < 65) begin
				txt.push_back(pick_delim());
			end else if (r < 75) begin
				txt.push_back(8'($urandom_range(255)));
			end else begin
				txt.push_back(pick_symbol());
			end
		end
	endfunction

	task automatic cfg_write(tfw_reg_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PAT_LO:      cfg_pat_lo = val;
			REG_PAT_HI:      cfg_pat_hi = val;
			REG_PAT_LEN:     cfg_len = val[4:0];
			REG_MATCH_CASE:  cfg_case = val[0];
			REG_WHOLE_WORD:  cfg_word = val[0];
			REG_SEARCH_DOWN: cfg_down = val[0];
			REG_SEL_START:   cfg_sel_start = val[15:0];
			REG_SEL_END:     cfg_sel_end = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_search(logic [127:0] pat, int len, bit mc, bit ww, bit dn, int ss, int se);
		cfg_write(REG_PAT_LO, pat[63:0]);
		cfg_write(REG_PAT_HI, pat[127:64]);
		cfg_write(REG_PAT_LEN, 64'(len & 31));
		cfg_write(REG_MATCH_CASE, 64'(mc));
		cfg_write(REG_WHOLE_WORD, 64'(ww));
		cfg_write(REG_SEARCH_DOWN, 64'(dn));
		cfg_write(REG_SEL_START, 64'(ss & 16'hFFFF));
		cfg_write(REG_SEL_END, 64'(se & 16'hFFFF));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending.size() > 0 || results_due.size() > 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One setting, then one to three texts back to back under it.
	task automatic random_group(inout int count);
		logic [127:0] pat;
		logic [7:0]   txt[$];
		int           copies[$];
		int           len_val;
		int           m;
		int           r;
		int           ss;
		int           se;
		int           extra;
		r = $urandom_range(99);
		if (r < 50) len_val = $urandom_range(3, 1);
		else if (r < 85) len_val = $urandom_range(8, 4);
		else if (r < 95) len_val = $urandom_range(16, 9);
		else len_val = $urandom_range(1) ? 0 : $urandom_range(31, 17);
		m = (len_val == 0) ? 1 : (len_val > PATTERN_MAX ? PATTERN_MAX : len_val);
		for (int i = 0; i < 16; i++) pat[8*i +: 8] = pick_symbol();
		build_text(pat, m, txt, copies);

		r = $urandom_range(99);
		if (r < 45 && copies.size() > 0) begin
			ss = copies[$urandom_range(copies.size() - 1)];
			se = ($urandom_range(99) < 70) ? ss + m : ss + m + $urandom_range(2) - 1;
		end else if (r < 70) begin
			ss = $urandom_range(txt.size() + 1);
			se = ss + $urandom_range(m + 1);
		end else if (r < 80) begin
			ss = $urandom_range(65535);
			se = $urandom_range(65535);
		end else if (r < 90) begin
			ss = 65535;
			se = $urandom_range(1) ? 65535 : 0;
		end else begin
			ss = 0;
			se = $urandom_range(1) ? 0 : m;
		end

		wait_idle();
		set_search(pat, len_val, $urandom_range(1), $urandom_range(1), $urandom_range(1), ss, se);
		queue_bytes(txt);
		count += txt.size();
		extra = $urandom_range(2);
		for (int k = 0; k < extra; k++) begin
			build_text(pat, m, txt, copies);
			queue_bytes(txt);
			count += txt.size();
		end
	endtask

	initial begin
		int phase_bytes;
		text_ch.valid = 1'b0;
		text_ch.text_char = 8'h00;
		text_ch.last_char = 1'b0;
		result_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PAT_LO;
		cfg_wdata = '0;
		cfg_pat_lo = '0;
		cfg_pat_hi = '0;
		cfg_len = 5'd1;
		cfg_case = 1'b0;
		cfg_word = 1'b0;
		cfg_down = 1'b1;
		cfg_sel_start = '0;
		cfg_sel_end = '0;
		clear_search();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset setting: one zero byte against a zero pattern byte
		pending.push_back('{8'h00, 1'b1});
		wait_idle();
		set_search(pack_str("Ab"), 2, 1'b0, 1'b0, 1'b1, 0, 0);
		queue_text("xaB");
		wait_idle();
		set_search(pack_str("Ab"), 2, 1'b1, 1'b0, 1'b1, 0, 0);
		queue_text("aBAb");
		// whole word: match at the text end counts downward only
		wait_idle();
		set_search(pack_str("ab"), 2, 1'b0, 1'b1, 1'b1, 1, 0);
		queue_text("ab.ab");
		wait_idle();
		set_search(pack_str("ab"), 2, 1'b0, 1'b1, 1'b0, 3, 0);
		queue_text("ab.ab");
		// selection already holds the pattern: shift the origin
		wait_idle();
		set_search(pack_str("ab"), 2, 1'b0, 1'b0, 1'b1, 0, 2);
		queue_text("abab");
		wait_idle();
		set_search(pack_str("ab"), 2, 1'b0, 1'b0, 1'b0, 0, 2);
		queue_text("abab");
		wait_idle();
		set_search(pack_str("ab"), 2, 1'b0, 1'b0, 1'b1, 100, 0);
		queue_text("ab");
		wait_idle();
		set_search(pack_str("A"), 0, 1'b1, 1'b0, 1'b1, 0, 0);
		queue_text("A");
		// clamped length, pattern longer than the text
		wait_idle();
		set_search({128{1'b1}}, 31, 1'b0, 1'b1, 1'b0, 65535, 65535);
		for (int i = 0; i < 3; i++) pending.push_back('{8'hFF, i == 2});

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			phase_bytes = 0;
			while (phase_bytes < 262) random_group(phase_bytes);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Searched %0d texts from %0d bytes: %0d matched, %0d overflowed; %0d mismatches",
			texts_done, bytes_sent, found_seen, overflow_texts, mismatches);
		if (mismatches == 0) begin
			$display("text_find_with_word_match test passed");
		end else begin
			$display("text_find_with_word_match test failed");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("timeout: %0d results outstanding", results_due.size());
		$display("text_find_with_word_match test failed");
		$finish;
	end

endmodule
